// ===== rtl/psab_pkg.sv =====
`default_nettype none

package psab_pkg;

  // frame store geometry
  localparam int STORE_BYTES = 262144;
  localparam int BANKS       = 4;
  localparam int BANK_DEPTH  = STORE_BYTES / BANKS;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int ADDR_W      = 32;

  // request codes
  localparam logic [1:0] OP_OPAQUE = 2'd0;
  localparam logic [1:0] OP_ALPHA  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_VIS_COLS        = 2'd0;
  localparam logic [1:0] CFG_VIS_ROWS        = 2'd1;
  localparam logic [1:0] CFG_ROW_PITCH       = 2'd2;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd3;

  // register reset values
  localparam logic [12:0] RST_VIS_COLS        = 13'd1024;
  localparam logic [12:0] RST_VIS_ROWS        = 13'd768;
  localparam logic [14:0] RST_ROW_PITCH       = 15'd4096;
  localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_BLEND,
    ST_WRITE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic mem_rd;
    logic load_blend;
    logic mem_wr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic skip;
    logic do_write;
    logic out_room;
  } status_t;

  // ((a+1)*fg + (256-a)*bg) >> 8, always fits in a byte
  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] fg, logic [7:0] bg);
    logic [8:0]  wf;
    logic [8:0]  wb;
    logic [17:0] sum;
    wf  = {1'b0, a} + 9'd1;
    wb  = 9'd256 - {1'b0, a};
    sum = 18'(wf * {1'b0, fg}) + 18'(wb * {1'b0, bg});
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psab_ctrl.sv =====
`default_nettype none

module psab_ctrl
  import psab_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (status.skip) begin
          state_next = ST_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cmd.load_blend = 1'b1;
        state_next     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.mem_wr = status.do_write;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_room) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/psab_datapath.sv =====
`default_nettype none

module psab_datapath
  import psab_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [23:0]        color,
  input  wire logic [7:0]         alpha,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [23:0]             pixel_color,
  output logic                    clipped,
  output logic                    out_of_store
);

  // configuration registers
  logic [12:0] vis_cols;
  logic [12:0] vis_rows;
  logic [14:0] row_pitch;
  logic [2:0]  bytes_per_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      vis_cols        <= RST_VIS_COLS;
      vis_rows        <= RST_VIS_ROWS;
      row_pitch       <= RST_ROW_PITCH;
      bytes_per_pixel <= RST_BYTES_PER_PIXEL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VIS_COLS:        vis_cols        <= cfg_data[12:0];
        CFG_VIS_ROWS:        vis_rows        <= cfg_data[12:0];
        CFG_ROW_PITCH:       row_pitch       <= cfg_data;
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // request word
  logic [1:0]  op_q;
  logic [15:0] x_q;
  logic [15:0] y_q;
  logic [23:0] color_q;
  logic [7:0]  alpha_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= op;
      x_q     <= x;
      y_q     <= y;
      color_q <= color;
      alpha_q <= alpha;
    end
  end

  // clip test and offset products
  logic        clip_q;
  logic [18:0] x_off_q;
  logic [30:0] y_off_q;

  always_ff @(posedge clk) begin
    clip_q  <= x_q[15] || y_q[15] ||
               (x_q >= {3'b000, vis_cols}) || (y_q >= {3'b000, vis_rows});
    x_off_q <= 19'(x_q) * 19'(bytes_per_pixel);
    y_off_q <= 31'(y_q) * 31'(row_pitch);
  end

  // byte address and store bound check
  logic [ADDR_W-1:0] byte_addr;
  logic [ADDR_W-1:0] addr_q;
  logic              oos_q;

  assign byte_addr = ADDR_W'(x_off_q) + ADDR_W'(y_off_q);

  always_ff @(posedge clk) begin
    addr_q <= byte_addr;
    oos_q  <= ({1'b0, byte_addr} + 33'd2) >= 33'(STORE_BYTES);
  end

  // byte banks: bank j holds bytes whose address is j modulo four
  logic [1:0]       lane_lo;
  logic [ROW_W-1:0] base_row;
  logic [ROW_W-1:0] clr_cnt;
  logic [7:0]       rd_data  [BANKS];
  logic [7:0]       wr_byte  [3];

  assign lane_lo  = addr_q[1:0];
  assign base_row = addr_q[ROW_W+1:2];

  for (genvar j = 0; j < BANKS; j++) begin : g_bank
    logic [7:0]       mem [BANK_DEPTH];
    logic [1:0]       k;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] bank_addr;
    logic             we;
    logic [7:0]       wdata;

    assign k         = 2'(j) - lane_lo;
    assign row       = base_row + ROW_W'(2'(j) < lane_lo);
    assign bank_addr = cmd.clear_en ? clr_cnt : row;
    assign we        = cmd.clear_en || (cmd.mem_wr && (k != 2'd3));
    assign wdata     = cmd.clear_en ? 8'h00 : wr_byte[(k == 2'd3) ? 2'd0 : k];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[bank_addr] <= wdata;
      end
      if (cmd.mem_rd) begin
        rd_data[j] <= mem[bank_addr];
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + ROW_W'(1);
    end
  end

  // pick the three stored bytes and blend
  logic [7:0]  old_byte [3];
  logic [23:0] rd_pix_q;
  logic        opaque;

  assign opaque = (op_q == OP_OPAQUE) || (alpha_q == ALPHA_OPAQUE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      old_byte[i] = rd_data[lane_lo + 2'(i)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_blend) begin
      rd_pix_q <= {old_byte[2], old_byte[1], old_byte[0]};
      for (int i = 0; i < 3; i++) begin
        wr_byte[i] <= opaque ? color_q[8*i +: 8]
                             : mix_channel(alpha_q, color_q[8*i +: 8], old_byte[i]);
      end
    end
  end

  // result register
  logic skip;

  assign skip = (op_q == OP_NONE) || clip_q || oos_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_color  <= ((op_q == OP_READ) && !skip) ? rd_pix_q : 24'h000000;
      clipped      <= (op_q != OP_NONE) && clip_q;
      out_of_store <= (op_q != OP_NONE) && !clip_q && oos_q;
    end
  end

  // status back to the controller
  assign status.clear_last = (clr_cnt == ROW_W'(BANK_DEPTH - 1));
  assign status.skip       = skip;
  assign status.do_write   = (op_q == OP_OPAQUE) ||
                             ((op_q == OP_ALPHA) && (alpha_q != ALPHA_CLEAR));
  assign status.out_room   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/pixel_store_alpha_blend.sv =====
// Pixel frame store with opaque writes, alpha-blended writes and reads.
// Request channel (in_valid/in_ready) carries op, x, y, color, alpha; each
// word gives exactly one result word on the result channel (out_valid/
// out_ready) with pixel_color, clipped and out_of_store.
// Register writes come on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and a write takes effect next cycle.
// Timing: a request is taken only while no other request is in flight.
// Clipped, out-of-store and unused-op requests skip the byte banks and go
// from the read state straight to the result; reads and writes go through
// a read, blend and write state of the single-port byte banks, and only
// opaque and non-clear alpha writes store bytes in the write state.
// Reset: registers return to 1024 x 768, pitch 4096, 4 bytes per pixel, and
// a clearing pass zeroes the store, one row of all four banks a cycle;
// in_ready stays low until it ends.
// Stall: a result waits in the output register; the next request can be
// accepted meanwhile, but its result waits until the previous one is taken.
`default_nettype none

module pixel_store_alpha_blend
  import psab_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [23:0]        color,
  input  wire logic [7:0]         alpha,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [23:0]             pixel_color,
  output logic                    clipped,
  output logic                    out_of_store
);

  cmd_t    cmd;
  status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  psab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  psab_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .x            (x),
    .y            (y),
    .color        (color),
    .alpha        (alpha),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_color  (pixel_color),
    .clipped      (clipped),
    .out_of_store (out_of_store)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import psab_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASES         = 8;

  // register values per phase, indexed by register code
  localparam logic [14:0] PHASE_REGS [PHASES][4] = '{
    '{15'd64,    15'd48,    15'd256,   15'd3},
    '{15'd4096,  15'd4096,  15'd16384, 15'd4},
    '{15'd1,     15'd1,     15'd1,     15'd3},
    '{15'h6000,  15'h7fff,  15'h7fff,  15'h7ffb},
    '{15'd200,   15'd300,   15'd600,   15'd0},
    '{15'd100,   15'd4096,  15'd128,   15'd7},
    '{15'd640,   15'd480,   15'd1920,  15'd3},
    '{15'd4096,  15'd0,     15'd16384, 15'd4}
  };

  // hot window base x, base y, word count, no-idle flag per phase
  localparam int PHASE_PLAN [PHASES][4] = '{
    '{0,   0,    90,  0},
    '{4,   13,   80,  0},
    '{0,   0,    40,  0},
    '{0,   0,    25,  0},
    '{190, 296,  80,  0},
    '{14,  2046, 80,  0},
    '{636, 2,    100, 1},
    '{0,   0,    20,  0}
  };

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0]        color;
    logic [7:0]         alpha;
  } pixel_req_t;

  typedef struct {
    logic [23:0] pixel_color;
    logic        clipped;
    logic        out_of_store;
  } pixel_res_t;

  // frame store predictor with its queue of expected result words
  class pixel_scoreboard;
    bit [7:0]    store_bytes [STORE_BYTES];
    logic [12:0] width  = RST_VIS_COLS;
    logic [12:0] height = RST_VIS_ROWS;
    logic [14:0] pitch  = RST_ROW_PITCH;
    logic [2:0]  bpp    = RST_BYTES_PER_PIXEL;
    pixel_res_t  expected_q [$];
    int          errors;
    int          results_seen;

    function void set_register(logic [1:0] idx, logic [14:0] data);
      case (idx)
        CFG_VIS_COLS:        width  = data[12:0];
        CFG_VIS_ROWS:        height = data[12:0];
        CFG_ROW_PITCH:       pitch  = data[14:0];
        CFG_BYTES_PER_PIXEL: bpp    = data[2:0];
        default: ;
      endcase
    endfunction

    // update the store for one accepted request word and queue its result
    function void note_request(pixel_req_t req);
      pixel_res_t res;
      longint     col;
      longint     row;
      longint     addr;
      int         a;
      int         fg;
      int         bg;
      res = '{24'd0, 1'b0, 1'b0};
      col = longint'({1'b0, req.x});
      row = longint'({1'b0, req.y});
      a   = int'(req.alpha);
      if (req.op != OP_NONE) begin
        // negative coordinates clip like ones past the screen
        if (req.x[15] || req.y[15] || col >= width || row >= height) begin
          res.clipped = 1'b1;
        end else begin
          addr = col * bpp + row * pitch;
          if (addr + 2 >= STORE_BYTES) begin
            res.out_of_store = 1'b1;
          end else if (req.op == OP_READ) begin
            res.pixel_color = {store_bytes[addr + 2], store_bytes[addr + 1], store_bytes[addr]};
          end else if (req.op == OP_OPAQUE || req.alpha == ALPHA_OPAQUE) begin
            for (int i = 0; i < 3; i++) store_bytes[addr + i] = req.color[8*i +: 8];
          end else if (req.alpha != ALPHA_CLEAR) begin
            // per channel blend against the stored byte
            for (int i = 0; i < 3; i++) begin
              fg = int'(req.color[8*i +: 8]);
              bg = int'(store_bytes[addr + i]);
              store_bytes[addr + i] = 8'(((a + 1) * fg + (256 - a) * bg) >> 8);
            end
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      errors++;
    endtask

    task check_result(pixel_res_t got);
      pixel_res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, pixel_color %06h", got.pixel_color));
      end else begin
        want = expected_q.pop_front();
        if (got.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("pixel_color %06h, expected %06h",
                                    got.pixel_color, want.pixel_color));
        if (got.clipped !== want.clipped)
          report_mismatch($sformatf("clipped %b, expected %b", got.clipped, want.clipped));
        if (got.out_of_store !== want.out_of_store)
          report_mismatch($sformatf("out_of_store %b, expected %b",
                                    got.out_of_store, want.out_of_store));
      end
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_VIS_COLS;
  logic [14:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         op        = OP_NONE;
  logic signed [15:0] x         = '0;
  logic signed [15:0] y         = '0;
  logic [23:0]        color     = '0;
  logic [7:0]         alpha     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [23:0]        pixel_color;
  logic               clipped;
  logic               out_of_store;

  bit                 no_idle;
  int                 quiet_cycles;
  pixel_scoreboard    sb = new();

  pixel_store_alpha_blend i_dut (
    .clk,
    .rst,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .op,
    .x,
    .y,
    .color,
    .alpha,
    .out_valid,
    .out_ready,
    .pixel_color,
    .clipped,
    .out_of_store
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // drive one request word after a random gap, leave valid high after acceptance
  task automatic send_request(pixel_req_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= req.op;
    x        <= req.x;
    y        <= req.y;
    color    <= req.color;
    alpha    <= req.alpha;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
  endtask

  // one register write word; valid stays high for a following write
  task automatic cfg_write(logic [1:0] idx, logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, data);
  endtask

  // stop sending and wait until every expected word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // coordinate on or next to a screen boundary
  function automatic logic signed [15:0] boundary_coord(logic [12:0] limit);
    case ($urandom_range(0, 3))
      0: return 16'(limit) - 16'sd1;
      1: return 16'(limit);
      2: return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // result side: random stalls, check each accepted word
  initial begin : result_side
    int unsigned stall;
    pixel_res_t  got;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{pixel_color, clipped, out_of_store};
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_req_t  req;
    int unsigned roll;
    int unsigned pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset geometry, store starts cleared
    send_request('{OP_READ,   16'sd0,    16'sd0,    24'h000000, 8'h00});
    send_request('{OP_OPAQUE, 16'sd0,    16'sd0,    24'hffffff, 8'h00});
    send_request('{OP_READ,   16'sd0,    16'sd0,    24'h000000, 8'hff});
    // invisible alpha leaves the pixel alone
    send_request('{OP_ALPHA,  16'sd0,    16'sd0,    24'h000000, ALPHA_CLEAR});
    send_request('{OP_READ,   16'sd0,    16'sd0,    24'hffffff, 8'h00});
    // full alpha stores the color as is
    send_request('{OP_ALPHA,  16'sd0,    16'sd0,    24'h123456, ALPHA_OPAQUE});
    send_request('{OP_READ,   16'sd0,    16'sd0,    24'h000000, 8'h00});
    send_request('{OP_ALPHA,  16'sd0,    16'sd0,    24'hff00ff, 8'h80});
    send_request('{OP_READ,   16'sd0,    16'sd0,    24'h000000, 8'h00});
    send_request('{OP_ALPHA,  16'sd1,    16'sd0,    24'hffffff, 8'h01});
    send_request('{OP_ALPHA,  16'sd1,    16'sd0,    24'h000000, 8'hfe});
    send_request('{OP_READ,   16'sd1,    16'sd0,    24'h000000, 8'h00});
    // last in-store corner, then the first row past the store
    send_request('{OP_OPAQUE, 16'sd1023, 16'sd63,   24'ha5c33c, 8'h00});
    send_request('{OP_READ,   16'sd1023, 16'sd63,   24'h000000, 8'h00});
    send_request('{OP_READ,   16'sd0,    16'sd64,   24'h000000, 8'h00});
    send_request('{OP_ALPHA,  16'sd0,    16'sd64,   24'hffffff, ALPHA_CLEAR});
    send_request('{OP_READ,   16'sd1023, 16'sd767,  24'h000000, 8'h00});
    // clipping at the screen edges and for negative positions
    send_request('{OP_OPAQUE, 16'sd1024, 16'sd0,    24'hffffff, 8'hff});
    send_request('{OP_READ,   16'sd0,    16'sd768,  24'h000000, 8'h00});
    send_request('{OP_OPAQUE, -16'sd1,   16'sd0,    24'hffffff, 8'hff});
    send_request('{OP_READ,   16'sd0,    16'sh8000, 24'h000000, 8'h00});
    send_request('{OP_OPAQUE, 16'sh7fff, 16'sh7fff, 24'hffffff, 8'hff});
    // unused op code answers all zero
    send_request('{OP_NONE,   -16'sd1,   -16'sd1,   24'hffffff, 8'hff});
    send_request('{OP_NONE,   16'sd0,    16'sd0,    24'hffffff, 8'hff});
    send_request('{OP_READ,   16'sd1,    16'sd0,    24'h000000, 8'h00});

    // random phases, each under its own geometry
    for (int p = 0; p < PHASES; p++) begin
      settle();
      cfg_write(CFG_VIS_COLS,        PHASE_REGS[p][CFG_VIS_COLS]);
      cfg_write(CFG_VIS_ROWS,        PHASE_REGS[p][CFG_VIS_ROWS]);
      cfg_write(CFG_ROW_PITCH,       PHASE_REGS[p][CFG_ROW_PITCH]);
      cfg_write(CFG_BYTES_PER_PIXEL, PHASE_REGS[p][CFG_BYTES_PER_PIXEL]);
      cfg_valid <= 1'b0;
      no_idle = PHASE_PLAN[p][3] != 0;
      for (int n = 0; n < PHASE_PLAN[p][2]; n++) begin
        roll      = $urandom_range(0, 99);
        req.color = 24'($urandom);
        req.alpha = 8'($urandom);
        case ($urandom_range(0, 9))
          0: req.alpha = ALPHA_CLEAR;
          1: req.alpha = ALPHA_OPAQUE;
          default: ;
        endcase
        // mostly a small window so reads and blends revisit written pixels
        if (roll < 75) begin
          req.x = 16'(PHASE_PLAN[p][0] + $urandom_range(0, 7));
          req.y = 16'(PHASE_PLAN[p][1] + $urandom_range(0, 3));
        end else if (roll < 85) begin
          req.x = boundary_coord(sb.width);
          req.y = boundary_coord(sb.height);
        end else begin
          req.x = 16'($urandom);
          req.y = 16'($urandom);
        end
        if (roll < 85) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) req.op = OP_OPAQUE;
          else if (pick < 70) req.op = OP_ALPHA;
          else if (pick < 97) req.op = OP_READ;
          else req.op = OP_NONE;
        end else begin
          req.op = 2'($urandom);
        end
        send_request(req);
      end
    end

    no_idle = 1'b0;
    settle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
